/* hw/rtl/rtp_pkg.sv */
// Shared constants, types and the trig table helper for the 2D point rotate-and-translate block.
`default_nettype none

package rtp_pkg;

    localparam int ANGLE_BITS  = 8;
    localparam int ANGLE_CODES = 1 << ANGLE_BITS;
    localparam int CELL_COUNT  = 2;
    localparam int REG_INDEX_BITS = 1;

    localparam real TWO_PI = 6.283185307179586;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } reg_index_t;

    // Cosine or sine of an angle in radians, scaled by 2^frac and rounded to nearest
    // with ties away from zero.
    function automatic longint trig_fixed(input real ang, input int frac, input bit want_sin);
        real v;
        v = want_sin ? $sin(ang) : $cos(ang);
        return longint'(v * (2.0 ** frac));
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rtp_cell.sv */
// One multiply-accumulate cell of the rotation chain; it hands a 90-degree turned coefficient pair on.
`default_nettype none

module rtp_cell #(
    parameter int COORD_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          coord_a_in,
    input  logic signed [COORD_BITS-1:0]          coord_b_in,
    input  logic signed [COEF_BITS-1:0]           coef_a_in,
    input  logic signed [COEF_BITS-1:0]           coef_b_in,
    input  logic signed [COORD_BITS+COEF_BITS-1:0] acc_x_in,
    input  logic signed [COORD_BITS+COEF_BITS-1:0] acc_y_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          coord_a_out,
    output logic signed [COORD_BITS-1:0]          coord_b_out,
    output logic signed [COEF_BITS-1:0]           coef_a_out,
    output logic signed [COEF_BITS-1:0]           coef_b_out,
    output logic signed [COORD_BITS+COEF_BITS-1:0] acc_x_out,
    output logic signed [COORD_BITS+COEF_BITS-1:0] acc_y_out
);

    localparam int AW = COORD_BITS + COEF_BITS;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] coord_a_reg;
    logic signed [COORD_BITS-1:0] coord_b_reg;
    logic signed [COEF_BITS-1:0]  coef_a_reg;
    logic signed [COEF_BITS-1:0]  coef_b_reg;
    logic signed [AW-1:0]         acc_x_reg;
    logic signed [AW-1:0]         acc_y_reg;

    logic signed [AW-1:0]         prod_x;
    logic signed [AW-1:0]         prod_y;
    logic signed [AW-1:0]         acc_x_next;
    logic signed [AW-1:0]         acc_y_next;
    logic                         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        prod_x     = AW'(coord_a_in) * AW'(coef_a_in);
        prod_y     = AW'(coord_a_in) * AW'(coef_b_in);
        acc_x_next = acc_x_in + prod_x;
        acc_y_next = acc_y_in + prod_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // The next cell works on the other coordinate with the pair turned by 90 degrees.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coord_a_reg <= coord_b_in;
            coord_b_reg <= coord_a_in;
            coef_a_reg  <= -coef_b_in;
            coef_b_reg  <= coef_a_in;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
        end
    end

    assign out_valid   = valid_reg;
    assign coord_a_out = coord_a_reg;
    assign coord_b_out = coord_b_reg;
    assign coef_a_out  = coef_a_reg;
    assign coef_b_out  = coef_b_reg;
    assign acc_x_out   = acc_x_reg;
    assign acc_y_out   = acc_y_reg;

endmodule

`default_nettype wire

/* hw/rtl/rtp_finish.sv */
// Output stage: scales the sums down toward zero, adds the origin, saturates and holds the result item.
`default_nettype none

module rtp_finish #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_BITS+FRAC_BITS+1:0] acc_x,
    input  logic signed [COORD_BITS+FRAC_BITS+1:0] acc_y,
    input  logic signed [COORD_BITS-1:0]           origin_x,
    input  logic signed [COORD_BITS-1:0]           origin_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_BITS-1:0]           world_x,
    output logic signed [COORD_BITS-1:0]           world_y,
    output logic                                   saturated
);

    localparam int AW = COORD_BITS + FRAC_BITS + 2;
    localparam int QW = COORD_BITS + 2;
    localparam int SW = COORD_BITS + 3;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] world_x_reg;
    logic signed [COORD_BITS-1:0] world_y_reg;
    logic                         saturated_reg;

    logic signed [SW-1:0]         sum_x;
    logic signed [SW-1:0]         sum_y;
    logic                         sat_x;
    logic                         sat_y;
    logic signed [COORD_BITS-1:0] world_x_next;
    logic signed [COORD_BITS-1:0] world_y_next;

    // A negative sum is biased up before the arithmetic shift so the quotient truncates toward zero.
    function automatic logic signed [SW-1:0] translate(
        input logic signed [AW-1:0]         acc,
        input logic signed [COORD_BITS-1:0] org
    );
        logic signed [AW-1:0] bias;
        logic signed [AW-1:0] adj;
        logic signed [QW-1:0] quo;
        bias = acc[AW-1] ? {{(AW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0;
        adj  = acc + bias;
        quo  = adj[AW-1:FRAC_BITS];
        return SW'(quo) + SW'(org);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum_x = translate(acc_x, origin_x);
        sum_y = translate(acc_y, origin_y);
        sat_x = !((&sum_x[SW-1:COORD_BITS-1]) || !(|sum_x[SW-1:COORD_BITS-1]));
        sat_y = !((&sum_y[SW-1:COORD_BITS-1]) || !(|sum_y[SW-1:COORD_BITS-1]));
        if (sat_x)
        begin
            world_x_next = sum_x[SW-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            world_x_next = sum_x[COORD_BITS-1:0];
        end
        if (sat_y)
        begin
            world_y_next = sum_y[SW-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            world_y_next = sum_y[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            world_x_reg   <= world_x_next;
            world_y_reg   <= world_y_next;
            saturated_reg <= sat_x || sat_y;
        end
    end

    assign out_valid = valid_reg;
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

/* hw/rtl/rotate_translate_point_2d.sv */
// Top level of the 2D point rotate-and-translate block: trig lookup, cell chain and output stage.
//
// Each input item carries a point in the object's local frame and an angle code; each
// result item carries the world position and a flag that tells whether a coordinate clamped.
// Both channels use valid and ready; an item moves when both are high at a clock edge.
// The origin registers are written through cfg_wen, cfg_addr and cfg_wdata; the user must
// write them only while the block is idle, which the block itself does not enforce. A write
// takes effect at the next edge. From acceptance to a valid result an item passes the trig
// table lookup, one multiply-accumulate cell per local coordinate, and the output register.
// Throughput is one item per cycle without a stall. Every stage carries its own valid bit
// and a stage takes a new item whenever it is empty or its successor takes its content, so
// bubbles close up and input keeps flowing while a finished result waits in the output
// register. When the receiver stalls long enough the pipeline fills and in_ready falls after
// four items. Reset clears all valid bits and sets both origins to zero.
`default_nettype none

module rotate_translate_point_2d #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int ANGLE_STEPS    = 200
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          local_x,
    input  logic signed [COORD_BITS-1:0]          local_y,
    input  logic [rtp_pkg::ANGLE_BITS-1:0]        angle_step,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          world_x,
    output logic signed [COORD_BITS-1:0]          world_y,
    output logic                                  saturated,
    input  logic                                  cfg_wen,
    input  logic [rtp_pkg::REG_INDEX_BITS-1:0]    cfg_addr,
    input  logic [COORD_BITS-1:0]                 cfg_wdata
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int AW = COORD_BITS + TW;
    localparam int NC = rtp_pkg::CELL_COUNT;

    logic signed [TW-1:0] cos_tab [rtp_pkg::ANGLE_CODES];
    logic signed [TW-1:0] sin_tab [rtp_pkg::ANGLE_CODES];

    for (genvar a = 0; a < rtp_pkg::ANGLE_CODES; a++)
    begin : g_tab
        localparam int     K     = a % ANGLE_STEPS;
        localparam bit     NEG   = (K > ANGLE_STEPS - K);
        localparam int     M     = NEG ? (ANGLE_STEPS - K) : K;
        localparam real    ANG   = rtp_pkg::TWO_PI * real'(M) / real'(ANGLE_STEPS);
        localparam longint COS_V = rtp_pkg::trig_fixed(ANG, TRIG_FRAC_BITS, 1'b0);
        localparam longint SIN_M = rtp_pkg::trig_fixed(ANG, TRIG_FRAC_BITS, 1'b1);
        localparam longint SIN_V = NEG ? -SIN_M : SIN_M;
        assign cos_tab[a] = TW'(COS_V);
        assign sin_tab[a] = TW'(SIN_V);
    end

    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (rtp_pkg::reg_index_t'(cfg_addr))
                rtp_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                rtp_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                         cell_valid [0:NC];
    logic                         cell_ready [0:NC];
    logic signed [COORD_BITS-1:0] cell_coord_a [0:NC];
    logic signed [COORD_BITS-1:0] cell_coord_b [0:NC];
    logic signed [TW-1:0]         cell_coef_a [0:NC];
    logic signed [TW-1:0]         cell_coef_b [0:NC];
    logic signed [AW-1:0]         cell_acc_x [0:NC];
    logic signed [AW-1:0]         cell_acc_y [0:NC];

    logic                         front_valid_reg;
    logic signed [COORD_BITS-1:0] front_x_reg;
    logic signed [COORD_BITS-1:0] front_y_reg;
    logic signed [TW-1:0]         front_cos_reg;
    logic signed [TW-1:0]         front_sin_reg;

    assign in_ready = !front_valid_reg || cell_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            front_x_reg   <= local_x;
            front_y_reg   <= local_y;
            front_cos_reg <= cos_tab[angle_step];
            front_sin_reg <= sin_tab[angle_step];
        end
    end

    assign cell_valid[0]   = front_valid_reg;
    assign cell_coord_a[0] = front_x_reg;
    assign cell_coord_b[0] = front_y_reg;
    assign cell_coef_a[0]  = front_cos_reg;
    assign cell_coef_b[0]  = front_sin_reg;
    assign cell_acc_x[0]   = '0;
    assign cell_acc_y[0]   = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        rtp_cell #(
            .COORD_BITS (COORD_BITS),
            .COEF_BITS  (TW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (cell_valid[i]),
            .in_ready    (cell_ready[i]),
            .coord_a_in  (cell_coord_a[i]),
            .coord_b_in  (cell_coord_b[i]),
            .coef_a_in   (cell_coef_a[i]),
            .coef_b_in   (cell_coef_b[i]),
            .acc_x_in    (cell_acc_x[i]),
            .acc_y_in    (cell_acc_y[i]),
            .out_valid   (cell_valid[i+1]),
            .out_ready   (cell_ready[i+1]),
            .coord_a_out (cell_coord_a[i+1]),
            .coord_b_out (cell_coord_b[i+1]),
            .coef_a_out  (cell_coef_a[i+1]),
            .coef_b_out  (cell_coef_b[i+1]),
            .acc_x_out   (cell_acc_x[i+1]),
            .acc_y_out   (cell_acc_y[i+1])
        );
    end

    rtp_finish #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (TRIG_FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[NC]),
        .in_ready  (cell_ready[NC]),
        .acc_x     (cell_acc_x[NC]),
        .acc_y     (cell_acc_y[NC]),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .world_x   (world_x),
        .world_y   (world_y),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

/* sim/rotate_translate_point_2d_tb.sv */
// Self-checking testbench for the 2D point rotate-and-translate block.
module rotate_translate_point_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int ANGLE_STEPS    = 200;
    localparam int SERIES_FRAC    = 59;
    localparam int SERIES_TERMS   = 44;
    localparam bit [63:0] TWO_PI_Q59 = 64'h3243F6A8885A308D;
    localparam longint TRIG_ONE   = 64'sd1 << TRIG_FRAC_BITS;
    localparam longint COORD_MAX  = 32767;
    localparam longint COORD_MIN  = -32768;
    localparam int PIPE_LATENCY   = 4;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_ITEMS    = 150;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] world_x;
        logic signed [COORD_BITS-1:0] world_y;
        logic                         saturated;
    } world_point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_BITS-1:0] local_x;
    logic signed [COORD_BITS-1:0] local_y;
    logic [rtp_pkg::ANGLE_BITS-1:0] angle_step;
    logic out_valid;
    logic out_ready;
    logic signed [COORD_BITS-1:0] world_x;
    logic signed [COORD_BITS-1:0] world_y;
    logic saturated;
    logic cfg_wen;
    rtp_pkg::reg_index_t cfg_addr;
    logic [COORD_BITS-1:0] cfg_wdata;

    longint cos_q14 [ANGLE_STEPS];
    longint sin_q14 [ANGLE_STEPS];
    logic signed [COORD_BITS-1:0] origin_x_now;
    logic signed [COORD_BITS-1:0] origin_y_now;
    world_point_t expected_world [$];
    bit idle_enable;
    bit valid_raised;
    int error_count;
    longint cycle_count;

    rotate_translate_point_2d dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .local_x    (local_x),
        .local_y    (local_y),
        .angle_step (angle_step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .world_x    (world_x),
        .world_y    (world_y),
        .saturated  (saturated),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always #5ns clk = ~clk;

    function automatic longint round_q14(input bit [63:0] pos, input bit [63:0] neg);
        int unsigned sh;
        sh = SERIES_FRAC - TRIG_FRAC_BITS;
        if (pos >= neg)
            return longint'((pos - neg + (64'd1 << (sh - 1))) >> sh);
        return -longint'((neg - pos + (64'd1 << (sh - 1))) >> sh);
    endfunction

    // Cosine and sine from an integer Taylor series with 59 fraction bits.
    function automatic void series_trig(input int unsigned k, output longint c,
                                        output longint s);
        bit [63:0] ang;
        bit [63:0] term;
        bit [63:0] cp;
        bit [63:0] cn;
        bit [63:0] sp;
        bit [63:0] sn;
        bit [127:0] prod;
        int unsigned m;
        int unsigned i;
        bit neg_sin;
        neg_sin = (k > ANGLE_STEPS - k);
        m = neg_sin ? ANGLE_STEPS - k : k;
        ang = (TWO_PI_Q59 / ANGLE_STEPS) * m + ((TWO_PI_Q59 % ANGLE_STEPS) * m) / ANGLE_STEPS;
        term = 64'd1 << SERIES_FRAC;
        cp = term;
        cn = '0;
        sp = '0;
        sn = '0;
        for (i = 1; i <= SERIES_TERMS; i++)
        begin
            prod = {64'd0, term} * {64'd0, ang};
            term = prod[SERIES_FRAC+63:SERIES_FRAC] / i;
            if (i % 2 == 1)
            begin
                if (((i - 1) / 2) % 2 == 1)
                    sn += term;
                else
                    sp += term;
            end
            else
            begin
                if ((i / 2) % 2 == 1)
                    cn += term;
                else
                    cp += term;
            end
        end
        c = round_q14(cp, cn);
        s = neg_sin ? round_q14(sn, sp) : round_q14(sp, sn);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v,
                                                                 inout logic sat);
        if (v > COORD_MAX)
        begin
            sat = 1'b1;
            return COORD_MAX[COORD_BITS-1:0];
        end
        if (v < COORD_MIN)
        begin
            sat = 1'b1;
            return COORD_MIN[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic world_point_t transform_point(input logic signed [COORD_BITS-1:0] x,
                                                     input logic signed [COORD_BITS-1:0] y,
                                                     input logic [7:0] angle);
        world_point_t r;
        longint c;
        longint s;
        longint wx;
        longint wy;
        logic sat;
        int unsigned k;
        k = angle % ANGLE_STEPS;
        c = cos_q14[k];
        s = sin_q14[k];
        wx = (longint'(x) * c - longint'(y) * s) / TRIG_ONE + longint'(origin_x_now);
        wy = (longint'(x) * s + longint'(y) * c) / TRIG_ONE + longint'(origin_y_now);
        sat = 1'b0;
        r.world_x = clamp_coord(wx, sat);
        r.world_y = clamp_coord(wy, sat);
        r.saturated = sat;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_origin();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3, 4, 5: return 16'($urandom_range(0, 2000)) - 16'd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(ANGLE_STEPS, 255));
        return 8'($urandom_range(0, ANGLE_STEPS - 1));
    endfunction

    task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic [7:0] angle);
        int unsigned gap;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            if (valid_raised)
            begin
                in_valid <= 1'b0;
                valid_raised = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        local_x <= x;
        local_y <= y;
        angle_step <= angle;
        valid_raised = 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_world.push_back(transform_point(x, y, angle));
    endtask

    task automatic drain_pipeline();
        if (valid_raised)
        begin
            in_valid <= 1'b0;
            valid_raised = 1'b0;
        end
        do @(posedge clk); while (expected_world.size() != 0);
    endtask

    // Only called with the block idle and at a rising edge.
    task automatic set_origin(input logic signed [COORD_BITS-1:0] ox,
                              input logic signed [COORD_BITS-1:0] oy);
        cfg_wen <= 1'b1;
        cfg_addr <= rtp_pkg::REG_ORIGIN_X;
        cfg_wdata <= ox;
        @(posedge clk);
        cfg_addr <= rtp_pkg::REG_ORIGIN_Y;
        cfg_wdata <= oy;
        @(posedge clk);
        cfg_wen <= 1'b0;
        origin_x_now = ox;
        origin_y_now = oy;
    endtask

    task automatic test_exact_angles();
        idle_enable = 1'b0;
        send_point(16'sd12345, -16'sd6789, 8'd0);
        send_point(16'sd12345, -16'sd6789, 8'd50);
        send_point(16'sd12345, -16'sd6789, 8'd100);
        send_point(16'sd12345, -16'sd6789, 8'd150);
    endtask

    task automatic test_angle_wrap();
        idle_enable = 1'b1;
        send_point(16'sd1000, 16'sd2000, 8'd200);
        send_point(16'sd1000, 16'sd2000, 8'd255);
        send_point(-16'sd3000, 16'sd77, 8'd250);
        send_point(16'sd4321, -16'sd1234, 8'd128);
    endtask

    task automatic test_coordinate_extremes();
        send_point(16'sh7fff, 16'sh7fff, 8'd0);
        send_point(16'sh8000, 16'sh8000, 8'd0);
        send_point(16'sh7fff, 16'sh8000, 8'd100);
        send_point(16'sh7fff, 16'sh7fff, 8'd25);
        send_point(16'sh8000, 16'sh8000, 8'd25);
        send_point(16'sd1, -16'sd1, 8'd199);
        drain_pipeline();
    endtask

    task automatic test_saturation();
        set_origin(16'sh7fff, 16'sh8000);
        send_point(16'sd5, -16'sd5, 8'd0);
        send_point(-16'sd5, 16'sd5, 8'd0);
        drain_pipeline();
        set_origin(16'sh8000, 16'sh7fff);
        send_point(-16'sd1, 16'sd1, 8'd0);
        send_point(16'sh7fff, 16'sh8000, 8'd0);
        drain_pipeline();
    endtask

    task automatic test_random_stream();
        int phase;
        int n;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            set_origin(rand_origin(), rand_origin());
            idle_enable = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_point(rand_coord(), rand_coord(), rand_angle());
            drain_pipeline();
        end
    endtask

    initial
    begin
        int unsigned k;
        in_valid <= 1'b0;
        local_x <= '0;
        local_y <= '0;
        angle_step <= '0;
        cfg_wen <= 1'b0;
        cfg_addr <= rtp_pkg::REG_ORIGIN_X;
        cfg_wdata <= '0;
        rst_n <= 1'b0;
        error_count = 0;
        valid_raised = 1'b0;
        idle_enable = 1'b0;
        origin_x_now = '0;
        origin_y_now = '0;
        for (k = 0; k < ANGLE_STEPS; k++)
            series_trig(k, cos_q14[k], sin_q14[k]);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_exact_angles();
        test_angle_wrap();
        test_coordinate_extremes();
        test_saturation();
        test_random_stream();
        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            if (!idle_enable)
                @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_world
        world_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_world.size() == 0)
            begin
                $error("Unexpected item: world_x %0d, world_y %0d", world_x, world_y);
                error_count++;
            end
            else
            begin
                want = expected_world.pop_front();
                if (world_x !== want.world_x)
                begin
                    $error("world_x: expected %0d, actual %0d", want.world_x, world_x);
                    error_count++;
                end
                if (world_y !== want.world_y)
                begin
                    $error("world_y: expected %0d, actual %0d", want.world_y, world_y);
                    error_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

/* files.f */
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_cell.sv
hw/rtl/rtp_finish.sv
hw/rtl/rotate_translate_point_2d.sv
sim/rotate_translate_point_2d_tb.sv
